### rtl/lcgj_pkg.sv
// Shared widths, register codes and record types of the LCG jump-ahead block.
package lcgj_pkg;

    localparam int WORD_W    = 48;
    localparam int HALF_W    = WORD_W / 2;
    localparam int STEP_W    = 32;
    localparam int CFG_IDX_W = 1;

    typedef logic [WORD_W-1:0] t_word;

    localparam t_word RESET_MULT = 48'h0005_DEEC_E66D;
    localparam t_word RESET_INC  = 48'h0000_0000_000B;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MULT = 1'b0,
        REG_INC  = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        t_word                data;
    } t_cfg_wr;

    typedef struct packed {
        t_word m;
        t_word a;
    } t_pow;

    typedef struct packed {
        logic              valid;
        logic [STEP_W-1:0] count;
        t_word             acc_m;
        t_word             acc_a;
    } t_stage;

endpackage

### rtl/lcgj_req_if.sv
// Request channel carrying a step count.
interface lcgj_req_if
    import lcgj_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [STEP_W-1:0] step_count;

    modport source (output valid, output step_count, input ready);
    modport sink   (input valid, input step_count, output ready);
endinterface

### rtl/lcgj_rsp_if.sv
// Result channel carrying the combined multiplier and increment.
interface lcgj_rsp_if
    import lcgj_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] jump_multiplier;
    logic [WORD_W-1:0] jump_increment;

    modport source (output valid, output jump_multiplier, output jump_increment, input ready);
    modport sink   (input valid, input jump_multiplier, input jump_increment, output ready);
endinterface

### rtl/lcgj_mul48.sv
// Two-stage multiply-add modulo 2^48 built from three half-width products.
module lcgj_mul48
    import lcgj_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_word i_a,
    input  t_word i_b,
    input  t_word i_c,
    output t_word o_p
);

    logic [WORD_W-1:0] n_lo;
    logic [HALF_W-1:0] n_cross;
    logic [WORD_W-1:0] r_lo;
    logic [HALF_W-1:0] r_cross;
    t_word             r_c;
    t_word             r_p;

    // Only the low half of the cross products reaches bits below 2^48.
    always_comb begin
        n_lo    = i_a[HALF_W-1:0] * i_b[HALF_W-1:0];
        n_cross = i_a[WORD_W-1:HALF_W] * i_b[HALF_W-1:0]
                + i_a[HALF_W-1:0] * i_b[WORD_W-1:HALF_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo    <= n_lo;
            r_cross <= n_cross;
            r_c     <= i_c;
            r_p     <= r_lo + {r_cross, {HALF_W{1'b0}}} + r_c;
        end
    end

    assign o_p = r_p;

endmodule

### rtl/lcgj_pow_table.sv
// Configuration registers and the sequencer that fills the table of step powers.
module lcgj_pow_table
    import lcgj_pkg::*;
#(
    parameter int USED_BITS = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg_wr i_cfg,
    output logic    o_ready,
    output t_pow    o_pow [USED_BITS]
);

    localparam int IDX_W = (USED_BITS > 1) ? $clog2(USED_BITS) : 1;

    typedef enum logic [4:0] {
        S_LOAD  = 5'b00001,
        S_STORE = 5'b00010,
        S_WAIT1 = 5'b00100,
        S_WAIT2 = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state     r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    t_word      r_cfg_m, r_cfg_a;
    t_word      r_pm, r_pa, n_pm, n_pa;
    t_word      w_sq, w_inc;
    t_pow       r_tab [USED_BITS];

    // Powers of the single step: (m, a) -> (m*m, (m + 1)*a).
    lcgj_mul48 u_mul_sq (
        .i_clk (i_clk),
        .i_en  (1'b1),
        .i_a   (r_pm),
        .i_b   (r_pm),
        .i_c   ('0),
        .o_p   (w_sq)
    );

    lcgj_mul48 u_mul_inc (
        .i_clk (i_clk),
        .i_en  (1'b1),
        .i_a   (r_pm + WORD_W'(1)),
        .i_b   (r_pa),
        .i_c   ('0),
        .o_p   (w_inc)
    );

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_pm    = r_pm;
        n_pa    = r_pa;
        case (r_state)
            S_LOAD: begin
                n_pm    = r_cfg_m;
                n_pa    = r_cfg_a;
                n_idx   = '0;
                n_state = S_STORE;
            end
            S_STORE: begin
                if (r_idx == IDX_W'(USED_BITS - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_WAIT1;
                end
            end
            S_WAIT1: begin
                n_state = S_WAIT2;
            end
            S_WAIT2: begin
                n_pm    = w_sq;
                n_pa    = w_inc;
                n_idx   = r_idx + IDX_W'(1);
                n_state = S_STORE;
            end
            S_DONE: begin
                n_state = S_DONE;
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
        // A new step definition restarts the table fill.
        if (i_cfg.we) begin
            n_state = S_LOAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_idx   <= '0;
            r_cfg_m <= RESET_MULT;
            r_cfg_a <= RESET_INC;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (i_cfg.we) begin
                case (t_cfg_reg'(i_cfg.index))
                    REG_MULT: r_cfg_m <= i_cfg.data;
                    REG_INC:  r_cfg_a <= i_cfg.data;
                    default:  ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pm <= n_pm;
        r_pa <= n_pa;
        if (r_state == S_STORE) begin
            r_tab[r_idx] <= '{m: r_pm, a: r_pa};
        end
    end

    assign o_ready = (r_state == S_DONE);
    assign o_pow   = r_tab;

endmodule

### rtl/lcgj_stage.sv
// One count bit of the pipeline: applies the matching step power when the bit is set.
module lcgj_stage
    import lcgj_pkg::*;
#(
    parameter int K = 0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  t_stage i_prev,
    input  t_pow   i_pow,
    output t_stage o_next
);

    logic              w_bit;
    t_word             w_mul_b, w_mul_c;
    t_word             w_acc_m, w_acc_a;
    logic [1:0]        r_valid;
    logic [STEP_W-1:0] r_count0, r_count1;

    // A clear bit multiplies by one and adds nothing, so the accumulators pass unchanged.
    always_comb begin
        w_bit   = i_prev.count[K];
        w_mul_b = w_bit ? i_pow.m : WORD_W'(1);
        w_mul_c = w_bit ? i_pow.a : '0;
    end

    lcgj_mul48 u_mul_m (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (i_prev.acc_m),
        .i_b   (w_mul_b),
        .i_c   ('0),
        .o_p   (w_acc_m)
    );

    lcgj_mul48 u_mul_a (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (i_prev.acc_a),
        .i_b   (w_mul_b),
        .i_c   (w_mul_c),
        .o_p   (w_acc_a)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[0], i_prev.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_count0 <= i_prev.count;
            r_count1 <= r_count0;
        end
    end

    assign o_next = '{valid: r_valid[1], count: r_count1, acc_m: w_acc_m, acc_a: w_acc_a};

endmodule

### rtl/lcg_jump_ahead_coefficients.sv
// Top level: jump-ahead coefficient pipeline for a 48-bit linear congruential generator.
//
// A request carries a step count n. The result gives M and A, modulo 2^48, such that
// n generator steps x' = x*mult + inc equal the single step x' = x*M + A. Only the low
// COUNT_BITS bits of n are used (at most the 32 bits of the field).
// The two step registers are written through the plain write port (index 0: multiplier,
// index 1: increment) and are reset to 0x5DEECE66D and 0xB.
// After reset and after every register write, a sequencer fills a table of the step's
// powers of two, one shared pair of multipliers working through a store state and two
// wait states between powers; requests are held off until the table is complete.
// Each count bit then has a pair of two-stage multiply-add units, and one request is
// taken every cycle while the table is complete and the output does not stall.
// The last stage is the output register. When the receiver stalls, the whole pipeline
// holds and request ready goes low; nothing is lost or repeated.
// Reset empties the pipeline and restarts the table fill.
module lcg_jump_ahead_coefficients
    import lcgj_pkg::*;
#(
    parameter int COUNT_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    lcgj_req_if.sink             i_req,
    lcgj_rsp_if.source           o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    localparam int USED_BITS = (COUNT_BITS < STEP_W) ? COUNT_BITS : STEP_W;

    t_cfg_wr w_cfg;
    logic    w_tab_ready;
    logic    w_en;
    t_pow    w_pow   [USED_BITS];
    t_stage  w_stage [USED_BITS+1];

    assign w_cfg = '{we: i_cfg_we, index: i_cfg_index, data: i_cfg_data};

    lcgj_pow_table #(
        .USED_BITS (USED_BITS)
    ) u_pow_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .o_ready (w_tab_ready),
        .o_pow   (w_pow)
    );

    // The pipeline moves as one unless a finished result is waiting.
    assign w_en        = !(w_stage[USED_BITS].valid && !o_rsp.ready);
    assign i_req.ready = w_tab_ready && w_en;

    assign w_stage[0] = '{valid: i_req.valid && i_req.ready,
                          count: i_req.step_count,
                          acc_m: WORD_W'(1),
                          acc_a: '0};

    for (genvar k = 0; k < USED_BITS; k++) begin : g_stage
        lcgj_stage #(
            .K (k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_prev  (w_stage[k]),
            .i_pow   (w_pow[k]),
            .o_next  (w_stage[k+1])
        );
    end

    assign o_rsp.valid           = w_stage[USED_BITS].valid;
    assign o_rsp.jump_multiplier = w_stage[USED_BITS].acc_m;
    assign o_rsp.jump_increment  = w_stage[USED_BITS].acc_a;

endmodule

### rtl/lcgj_checker.sv
// Port-level checks of the jump-ahead block, bound to its top level.
module lcgj_checker
    import lcgj_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_ready,
    input logic              i_rsp_valid,
    input logic              i_rsp_ready,
    input logic [WORD_W-1:0] i_rsp_mult,
    input logic [WORD_W-1:0] i_rsp_inc,
    input logic              i_cfg_we
);

    // A waiting result keeps its value until it is taken.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_mult)
                                        && $stable(i_rsp_inc))
        else $error("result changed while stalled");

    // A stalled result stops the whole pipeline, so no request may enter.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |-> !i_req_ready)
        else $error("request accepted during output stall");

    // A register write restarts the power table, which holds off requests.
    a_cfg_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !i_req_ready)
        else $error("request ready right after register write");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid && !i_req_ready)
        else $error("pipeline not empty after reset");

endmodule

bind lcg_jump_ahead_coefficients lcgj_checker u_lcgj_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_mult  (o_rsp.jump_multiplier),
    .i_rsp_inc   (o_rsp.jump_increment),
    .i_cfg_we    (i_cfg_we)
);
